/* rtl/core/pcdq_pkg.sv */
// Package for the per-cell delayed decision queue.
// Holds command and sequencer state codes, field widths and register indexes.
// No dependencies.
package pcdq_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CELLREQ_W = 2;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned DIR_IDX_W = 2;

  localparam int unsigned DIRECT_FIRST = 1;
  localparam int unsigned DIRECT_LAST  = 3;

  localparam logic REG_CHANNEL_DELAY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_TAKE   = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_FRONT  = 3'd3,
    CMD_DIRECT = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PR_RD0,
    ST_PR_CHK0,
    ST_PR_RD1,
    ST_PR_CHK1,
    ST_WK_RD,
    ST_WK_CHK,
    ST_FR_RD,
    ST_FR_CHK,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/per_cell_delayed_decision_queue.sv */
// Per-cell delayed decision queue: one timestamped FIFO of decision bits per cell.
// A push stores the entry, then prunes expired head entries once the fill reaches PRUNE_AT;
// take and peek walk the due entries; front peek reads the head entry; a direct query walks
// cells 1 to 3 in turn; an unknown command returns a result with every field zero.
// One transaction at a time: the next is accepted once the result is registered,
// and a stalled result holds the sequencer. Reset (rst_ni low, async) empties every queue.
module per_cell_delayed_decision_queue #(
  parameter int unsigned NUM_CELLS   = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PRUNE_AT    = 10,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cmd[2:0], cell_req[4:3], now[TIME_BITS+4:5], decision_in[TIME_BITS+5], zero fill
  input  logic [((TIME_BITS+13)/8)*8-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // decision_out[0], found[1], direct_index[3:2], dual[4], overflow[5], zero fill
  output logic [pcdq_pkg::OUT_W-1:0]          m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcdq_pkg::PADDR_W-1:0]        paddr,
  input  logic [pcdq_pkg::PDATA_W-1:0]        pwdata,
  output logic [pcdq_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int unsigned CELL_W = $clog2(NUM_CELLS);
  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = CELL_W + SLOT_W;
  localparam int unsigned ENT_W  = TIME_BITS + 1;
  localparam int unsigned SUM_W  =
    ((TIME_BITS > pcdq_pkg::DELAY_W) ? TIME_BITS : pcdq_pkg::DELAY_W) + 1;
  localparam int unsigned NOW_LO = pcdq_pkg::CMD_W + pcdq_pkg::CELLREQ_W;
  localparam int unsigned BIT_POS = NOW_LO + TIME_BITS;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  pcdq_pkg::state_e state_q, state_d;
  pcdq_pkg::cmd_e   cmd_q, cmd_d;
  logic [CELL_W-1:0]    cell_q, cell_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] rel_q, rel_d;
  logic                 bit_q, bit_d;
  logic [SLOT_W-1:0]    w_head_q, w_head_d;
  logic [CNT_W-1:0]     w_cnt_q, w_cnt_d;
  logic                 res_q, res_d;
  logic                 dec_q, dec_d;
  logic                 found_q, found_d;
  logic [pcdq_pkg::DIR_IDX_W-1:0] idx_q, idx_d;
  logic                 dual_q, dual_d;
  logic                 ovf_q, ovf_d;
  logic                 mvalid_q, mvalid_d;
  logic [pcdq_pkg::OUT_W-1:0] mdata_q, mdata_d;
  logic [pcdq_pkg::DELAY_W-1:0] delay_q;

  logic [SLOT_W-1:0] head_q [NUM_CELLS];
  logic [SLOT_W-1:0] head_d [NUM_CELLS];
  logic [CNT_W-1:0]  cnt_q  [NUM_CELLS];
  logic [CNT_W-1:0]  cnt_d  [NUM_CELLS];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  logic [TIME_BITS-1:0] rd_time;
  logic                 rd_bit;
  logic                 in_accept;
  logic [pcdq_pkg::CMD_W-1:0] in_cmd;
  logic [CELL_W-1:0]    in_cell;
  logic [CELL_W-1:0]    walk_cell;
  logic [TIME_BITS-1:0] in_now;
  logic [SUM_W-1:0]     rel_sum;
  logic [SLOT_W-1:0]    cur_head;
  logic [SLOT_W-1:0]    cur_head_nx;
  logic [CNT_W-1:0]     cur_cnt;
  logic [CNT_W-1:0]     cnt_new;
  logic [SLOT_W:0]      slot_sum;
  logic [SLOT_W-1:0]    push_slot;
  logic                 walk_end;
  logic                 walk_res;
  logic [CELL_W-1:0]    cell_nx;
  logic                 cfg_we;

  pcdq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_time = mem_rdata[TIME_BITS:1];
  assign rd_bit  = mem_rdata[0];

  assign s_axis_tready = (state_q == pcdq_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = s_axis_tdata[pcdq_pkg::CMD_W-1:0];
  assign in_cell       = CELL_W'(s_axis_tdata[NOW_LO-1:pcdq_pkg::CMD_W]);
  assign in_now        = s_axis_tdata[BIT_POS-1:NOW_LO];
  assign walk_cell     = (in_cmd == pcdq_pkg::CMD_DIRECT) ?
                         CELL_W'(pcdq_pkg::DIRECT_FIRST) : in_cell;
  assign rel_sum       = SUM_W'(in_now) + SUM_W'(delay_q);

  assign cur_head    = head_q[cell_q];
  assign cur_head_nx = next_slot(cur_head);
  assign cur_cnt     = cnt_q[cell_q];
  assign slot_sum    = (SLOT_W+1)'(cur_head) + (SLOT_W+1)'(cur_cnt);
  assign push_slot   = (slot_sum >= (SLOT_W+1)'(QUEUE_DEPTH)) ?
                       SLOT_W'(slot_sum - (SLOT_W+1)'(QUEUE_DEPTH)) : SLOT_W'(slot_sum);
  assign cell_nx     = cell_q + CELL_W'(1);

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[pcdq_pkg::PADDR_W-1] == pcdq_pkg::REG_CHANNEL_DELAY) ?
                  pcdq_pkg::PDATA_W'(delay_q) : '0;

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cell_d    = cell_q;
    now_d     = now_q;
    rel_d     = rel_q;
    bit_d     = bit_q;
    w_head_d  = w_head_q;
    w_cnt_d   = w_cnt_q;
    res_d     = res_q;
    dec_d     = dec_q;
    found_d   = found_q;
    idx_d     = idx_q;
    dual_d    = dual_q;
    ovf_d     = ovf_q;
    mvalid_d  = mvalid_q;
    mdata_d   = mdata_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_waddr = {cell_q, push_slot};
    mem_wdata = {rel_q, bit_q};
    mem_raddr = {cell_q, cur_head};
    walk_end  = 1'b0;
    walk_res  = res_q;
    cnt_new   = cur_cnt;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      pcdq_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_d    = pcdq_pkg::cmd_e'(in_cmd);
          cell_d   = walk_cell;
          now_d    = in_now;
          bit_d    = s_axis_tdata[BIT_POS];
          rel_d    = (|(rel_sum >> TIME_BITS)) ? '1 : rel_sum[TIME_BITS-1:0];
          w_head_d = head_q[walk_cell];
          w_cnt_d  = cnt_q[walk_cell];
          res_d    = 1'b0;
          dec_d    = 1'b0;
          found_d  = 1'b0;
          idx_d    = '0;
          dual_d   = 1'b0;
          ovf_d    = 1'b0;
          unique case (pcdq_pkg::cmd_e'(in_cmd))
            pcdq_pkg::CMD_PUSH:   state_d = pcdq_pkg::ST_PUSH;
            pcdq_pkg::CMD_TAKE,
            pcdq_pkg::CMD_PEEK,
            pcdq_pkg::CMD_DIRECT: state_d = pcdq_pkg::ST_WK_RD;
            pcdq_pkg::CMD_FRONT:  state_d = pcdq_pkg::ST_FR_RD;
            default:              state_d = pcdq_pkg::ST_DONE;
          endcase
        end
      end
      pcdq_pkg::ST_PUSH: begin
        if (cur_cnt >= CNT_W'(QUEUE_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          mem_we         = 1'b1;
          cnt_new        = cur_cnt + CNT_W'(1);
          cnt_d[cell_q]  = cnt_new;
        end
        state_d = (32'(cnt_new) >= 32'(PRUNE_AT)) ? pcdq_pkg::ST_PR_RD0 : pcdq_pkg::ST_DONE;
      end
      pcdq_pkg::ST_PR_RD0: begin
        state_d = (cur_cnt < CNT_W'(2)) ? pcdq_pkg::ST_DONE : pcdq_pkg::ST_PR_CHK0;
      end
      pcdq_pkg::ST_PR_CHK0: begin
        state_d = (rd_time < now_q) ? pcdq_pkg::ST_PR_RD1 : pcdq_pkg::ST_DONE;
      end
      pcdq_pkg::ST_PR_RD1: begin
        mem_raddr = {cell_q, cur_head_nx};
        state_d   = (cur_cnt < CNT_W'(2)) ? pcdq_pkg::ST_DONE : pcdq_pkg::ST_PR_CHK1;
      end
      pcdq_pkg::ST_PR_CHK1: begin
        if (rd_time < now_q) begin
          head_d[cell_q] = cur_head_nx;
          cnt_d[cell_q]  = cur_cnt - CNT_W'(1);
          state_d        = pcdq_pkg::ST_PR_RD1;
        end else begin
          state_d = pcdq_pkg::ST_DONE;
        end
      end
      pcdq_pkg::ST_WK_RD: begin
        mem_raddr = {cell_q, w_head_q};
        if (w_cnt_q == '0) begin
          walk_end = 1'b1;
        end else begin
          state_d = pcdq_pkg::ST_WK_CHK;
        end
      end
      pcdq_pkg::ST_WK_CHK: begin
        mem_raddr = {cell_q, w_head_q};
        if (rd_time <= now_q) begin
          walk_res = rd_bit;
          if (w_cnt_q > CNT_W'(1)) begin
            w_head_d = next_slot(w_head_q);
            w_cnt_d  = w_cnt_q - CNT_W'(1);
            res_d    = rd_bit;
            state_d  = pcdq_pkg::ST_WK_RD;
          end else begin
            walk_end = 1'b1;
          end
        end else begin
          walk_end = 1'b1;
        end
      end
      pcdq_pkg::ST_FR_RD: begin
        state_d = (cur_cnt == '0) ? pcdq_pkg::ST_DONE : pcdq_pkg::ST_FR_CHK;
      end
      pcdq_pkg::ST_FR_CHK: begin
        dec_d   = rd_bit;
        state_d = pcdq_pkg::ST_DONE;
      end
      pcdq_pkg::ST_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = pcdq_pkg::OUT_W'({ovf_q, dual_q, idx_q, found_q, dec_q});
          state_d  = pcdq_pkg::ST_IDLE;
        end
      end
      default: state_d = pcdq_pkg::ST_IDLE;
    endcase

    if (walk_end) begin
      priority case (cmd_q)
        pcdq_pkg::CMD_TAKE: begin
          head_d[cell_q] = w_head_q;
          cnt_d[cell_q]  = w_cnt_q;
          dec_d          = walk_res;
          state_d        = pcdq_pkg::ST_DONE;
        end
        pcdq_pkg::CMD_DIRECT: begin
          if (walk_res) begin
            if (!found_q) begin
              found_d = 1'b1;
              idx_d   = pcdq_pkg::DIR_IDX_W'(cell_q - CELL_W'(pcdq_pkg::DIRECT_FIRST));
            end else begin
              dual_d = 1'b1;
            end
          end
          if (cell_q == CELL_W'(pcdq_pkg::DIRECT_LAST)) begin
            state_d = pcdq_pkg::ST_DONE;
          end else begin
            cell_d   = cell_nx;
            w_head_d = head_q[cell_nx];
            w_cnt_d  = cnt_q[cell_nx];
            res_d    = 1'b0;
            state_d  = pcdq_pkg::ST_WK_RD;
          end
        end
        default: begin
          dec_d   = walk_res;
          state_d = pcdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcdq_pkg::ST_IDLE;
      mvalid_q <= 1'b0;
      delay_q  <= '0;
      for (int c = 0; c < NUM_CELLS; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      if (cfg_we && (paddr[pcdq_pkg::PADDR_W-1] == pcdq_pkg::REG_CHANNEL_DELAY)) begin
        delay_q <= pwdata[pcdq_pkg::DELAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    cell_q   <= cell_d;
    now_q    <= now_d;
    rel_q    <= rel_d;
    bit_q    <= bit_d;
    w_head_q <= w_head_d;
    w_cnt_q  <= w_cnt_d;
    res_q    <= res_d;
    dec_q    <= dec_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    dual_q   <= dual_d;
    ovf_q    <= ovf_d;
    mdata_q  <= mdata_d;
  end

endmodule

/* rtl/core/pcdq_ram.sv */
// Single-port-write, single-port-read entry store with registered read data.
// Holds the release time and decision bit of every queue slot of every cell.
// No dependencies.
module pcdq_ram #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 33
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pcdq_checker.sv */
// Port-level checks for the per-cell delayed decision queue, bound to the top level.
// Depends on pcdq_pkg and per_cell_delayed_decision_queue.
module pcdq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [pcdq_pkg::OUT_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input transaction accepted while previous still in work");

  a_direct_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[3:2] == 2'd0 && !m_axis_tdata[4])
    else $error("direct index or dual set without a found cell");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones({m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[5]}) <= 1
                      && m_axis_tdata[3:2] != 2'd3 && m_axis_tdata[7:6] == 2'd0)
    else $error("result mixes fields of different commands");

endmodule

bind per_cell_delayed_decision_queue pcdq_checker u_pcdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_per_cell_delayed_decision_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for per_cell_delayed_decision_queue: drives commands on the
// input stream, predicts each answer from its own copy of the per-cell queues and checks
// every result; the delay register is set over APB. Depends on pcdq_pkg and the RTL.
module tb_per_cell_delayed_decision_queue;

  localparam int unsigned NUM_CELLS    = 4;
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned PRUNE_AT     = 10;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned IN_W         = ((TIME_BITS + 13) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 150;

  localparam logic [pcdq_pkg::CMD_W-1:0]   CMD_RSVD_LO = 3'd5;
  localparam logic [pcdq_pkg::CMD_W-1:0]   CMD_RSVD_HI = 3'd7;
  localparam logic [pcdq_pkg::PADDR_W-1:0] DELAY_ADDR  = {pcdq_pkg::REG_CHANNEL_DELAY, 2'b00};
  localparam logic [TIME_BITS-1:0]         TIME_MAX    = '1;

  typedef logic [TIME_BITS-1:0] tick_t;

  typedef struct packed {
    logic                           overflow;
    logic                           dual;
    logic [pcdq_pkg::DIR_IDX_W-1:0] index;
    logic                           found;
    logic                           decision;
  } answer_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic [IN_W-1:0]                s_axis_tdata  = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pcdq_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [pcdq_pkg::PADDR_W-1:0]   paddr         = '0;
  logic [pcdq_pkg::PDATA_W-1:0]   pwdata        = '0;
  logic [pcdq_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  per_cell_delayed_decision_queue #(
    .NUM_CELLS  (NUM_CELLS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PRUNE_AT   (PRUNE_AT),
    .TIME_BITS  (TIME_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  tick_t              rel_time [NUM_CELLS][QUEUE_DEPTH];
  logic               dec_bit  [NUM_CELLS][QUEUE_DEPTH];
  int unsigned        head_ptr [NUM_CELLS] = '{default: 0};
  int unsigned        fill     [NUM_CELLS] = '{default: 0};
  logic [pcdq_pkg::DELAY_W-1:0] delay_ticks = '0;
  answer_t            answer_q[$];

  tick_t       time_base      = '0;
  int unsigned tx_idle_pct    = 10;
  int unsigned rx_stall_pct   = 56;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned accepted       = 0;
  int unsigned dropped_pushes = 0;
  int unsigned pruned_entries = 0;
  int unsigned direct_hits    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [pcdq_pkg::CELLREQ_W-1:0] rand_cell();
    int unsigned r;
    r = $urandom_range(NUM_CELLS - 1);
    return r[pcdq_pkg::CELLREQ_W-1:0];
  endfunction

  function automatic logic rand_bit();
    int unsigned r;
    r = $urandom_range(1);
    return r[0];
  endfunction

  function automatic logic walk_due(input int unsigned c, input tick_t now_t,
                                    input logic commit);
    int unsigned h;
    int unsigned n;
    logic        ans;
    logic        busy;
    h    = head_ptr[c];
    n    = fill[c];
    ans  = 1'b0;
    busy = 1'b1;
    while (busy && n > 0 && rel_time[c][h] <= now_t) begin
      ans = dec_bit[c][h];
      if (n > 1) begin
        h = (h + 1) % QUEUE_DEPTH;
        n--;
      end else begin
        busy = 1'b0;
      end
    end
    if (commit) begin
      head_ptr[c] = h;
      fill[c]     = n;
    end
    return ans;
  endfunction

  function automatic logic push_decision(input int unsigned c, input tick_t now_t,
                                         input logic b);
    logic [TIME_BITS:0] sum;
    tick_t              rel;
    logic               drop;
    int unsigned        s;
    sum  = (TIME_BITS+1)'(now_t) + (TIME_BITS+1)'(delay_ticks);
    rel  = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    drop = (fill[c] >= QUEUE_DEPTH);
    if (!drop) begin
      s              = (head_ptr[c] + fill[c]) % QUEUE_DEPTH;
      rel_time[c][s] = rel;
      dec_bit[c][s]  = b;
      fill[c]++;
    end else begin
      dropped_pushes++;
    end
    if (fill[c] >= PRUNE_AT) begin
      while (fill[c] >= 2 && rel_time[c][head_ptr[c]] < now_t &&
             rel_time[c][(head_ptr[c] + 1) % QUEUE_DEPTH] < now_t) begin
        head_ptr[c] = (head_ptr[c] + 1) % QUEUE_DEPTH;
        fill[c]--;
        pruned_entries++;
      end
    end
    return drop;
  endfunction

  function automatic answer_t predict_answer(input logic [pcdq_pkg::CMD_W-1:0] cmd,
                                             input logic [pcdq_pkg::CELLREQ_W-1:0] c,
                                             input tick_t now_t, input logic b);
    answer_t     a;
    int unsigned k;
    int unsigned rank;
    a = '0;
    case (cmd)
      pcdq_pkg::CMD_PUSH:  a.overflow = push_decision(c, now_t, b);
      pcdq_pkg::CMD_TAKE:  a.decision = walk_due(c, now_t, 1'b1);
      pcdq_pkg::CMD_PEEK:  a.decision = walk_due(c, now_t, 1'b0);
      pcdq_pkg::CMD_FRONT: a.decision = (fill[c] != 0) ? dec_bit[c][head_ptr[c]] : 1'b0;
      pcdq_pkg::CMD_DIRECT: begin
        for (k = pcdq_pkg::DIRECT_FIRST; k <= pcdq_pkg::DIRECT_LAST; k++) begin
          if (walk_due(k, now_t, 1'b0)) begin
            if (!a.found) begin
              a.found = 1'b1;
              rank    = k - pcdq_pkg::DIRECT_FIRST;
              a.index = rank[pcdq_pkg::DIR_IDX_W-1:0];
            end else begin
              a.dual = 1'b1;
            end
          end
        end
        if (a.found) direct_hits++;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t want;
    answer_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[$bits(answer_t)-1:0];
      if (answer_q.size() == 0) begin
        $error("result transaction with no command pending: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = answer_q[0];
        answer_q.delete(0);
        check_field("decision_out", {1'b0, want.decision}, {1'b0, seen.decision});
        check_field("found", {1'b0, want.found}, {1'b0, seen.found});
        check_field("direct_index", want.index, seen.index);
        check_field("dual", {1'b0, want.dual}, {1'b0, seen.dual});
        check_field("overflow", {1'b0, want.overflow}, {1'b0, seen.overflow});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout with %0d results outstanding", answer_q.size());
      $display("[per_cell_delayed_decision_queue] ERROR");
      $finish;
    end
  end

  task automatic send_cmd(input logic [pcdq_pkg::CMD_W-1:0] cmd,
                          input logic [pcdq_pkg::CELLREQ_W-1:0] c,
                          input tick_t now_t, input logic b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({b, now_t, c, cmd});
    do @(posedge clk_i); while (!s_axis_tready);
    answer_q.insert(answer_q.size(), predict_answer(cmd, c, now_t, b));
    accepted++;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [pcdq_pkg::DELAY_W-1:0] value);
    logic [pcdq_pkg::PDATA_W-1:0] word;
    word                          = $urandom;
    word[pcdq_pkg::DELAY_W-1:0]   = value;
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DELAY_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    delay_ticks = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[pcdq_pkg::DELAY_W-1:0] !== value) begin
      $error("channel_delay readback: expected %0d, got %0d", value,
             prdata[pcdq_pkg::DELAY_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_empty_queues();
    send_cmd(pcdq_pkg::CMD_TAKE, 2'd0, '0, 1'b0);
    send_cmd(pcdq_pkg::CMD_PEEK, 2'd1, TIME_MAX, 1'b1);
    send_cmd(pcdq_pkg::CMD_FRONT, 2'd2, '0, 1'b0);
    send_cmd(pcdq_pkg::CMD_DIRECT, 2'd3, TIME_MAX, 1'b1);
  endtask

  task automatic test_reserved_commands();
    int k;
    for (k = CMD_RSVD_LO; k <= CMD_RSVD_HI; k++) begin
      send_cmd(k[pcdq_pkg::CMD_W-1:0], rand_cell(), $urandom, rand_bit());
    end
  endtask

  task automatic test_release_saturation();
    write_delay('1);
    send_cmd(pcdq_pkg::CMD_PUSH, 2'd3, 32'hFFFF_0000, 1'b0);
    send_cmd(pcdq_pkg::CMD_PUSH, 2'd3, TIME_MAX - 1, 1'b1);
    send_cmd(pcdq_pkg::CMD_PEEK, 2'd3, TIME_MAX - 1, 1'b0);
    send_cmd(pcdq_pkg::CMD_DIRECT, 2'd0, TIME_MAX, 1'b0);
    // leave a reachable entry at the head for later traffic
    send_cmd(pcdq_pkg::CMD_PUSH, 2'd3, '0, 1'b0);
    send_cmd(pcdq_pkg::CMD_TAKE, 2'd3, TIME_MAX, 1'b0);
  endtask

  task automatic test_queue_full();
    write_delay('0);
    repeat (QUEUE_DEPTH) send_cmd(pcdq_pkg::CMD_PUSH, 2'd0, 32'd100, rand_bit());
    send_cmd(pcdq_pkg::CMD_PUSH, 2'd0, 32'd101, 1'b1);
    send_cmd(pcdq_pkg::CMD_FRONT, 2'd0, 32'd101, 1'b0);
  endtask

  task automatic test_random_traffic(input int n, input int unsigned tx_pct,
                                     input int unsigned rx_pct,
                                     input logic [pcdq_pkg::DELAY_W-1:0] value);
    int                             i;
    int                             len;
    int                             r;
    logic [pcdq_pkg::CMD_W-1:0]     cmd;
    logic [pcdq_pkg::CELLREQ_W-1:0] c;
    tick_t                          t;
    write_delay(value);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    i = 0;
    while (i < n) begin
      c = rand_cell();
      if ($urandom_range(99) < 6) begin
        len = $urandom_range(6, 18);
        repeat (len) begin
          time_base += $urandom_range(2);
          send_cmd(pcdq_pkg::CMD_PUSH, c, time_base, rand_bit());
        end
        i += len;
      end else begin
        r = $urandom_range(99);
        if (r < 38)      cmd = pcdq_pkg::CMD_PUSH;
        else if (r < 58) cmd = pcdq_pkg::CMD_TAKE;
        else if (r < 70) cmd = pcdq_pkg::CMD_PEEK;
        else if (r < 80) cmd = pcdq_pkg::CMD_FRONT;
        else if (r < 94) cmd = pcdq_pkg::CMD_DIRECT;
        else begin
          r   = $urandom_range(CMD_RSVD_LO, CMD_RSVD_HI);
          cmd = r[pcdq_pkg::CMD_W-1:0];
        end
        time_base += $urandom_range(3);
        t = ($urandom_range(99) < ((cmd == pcdq_pkg::CMD_PUSH) ? 1 : 5)) ?
            tick_t'($urandom) : time_base;
        send_cmd(cmd, c, t, rand_bit());
        i++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queues();
    test_reserved_commands();
    test_release_saturation();
    test_queue_full();
    time_base = 70000;
    test_random_traffic(240, 10, 56, 3);
    test_random_traffic(240, 56, 10, 0);
    test_random_traffic(240, 0, 0, 17);
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d commands under three stall profiles and five delay settings.",
             accepted);
    $display("Saw %0d full-queue drops, %0d pruned entries, %0d direct-query hits.",
             dropped_pushes, pruned_entries, direct_hits);
    if (error_count == 0) begin
      $display("[per_cell_delayed_decision_queue] OK");
    end else begin
      $display("[per_cell_delayed_decision_queue] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/pcdq_pkg.sv
rtl/core/pcdq_ram.sv
rtl/core/per_cell_delayed_decision_queue.sv
rtl/core/pcdq_checker.sv
tb/tb_per_cell_delayed_decision_queue.sv
